// ----- hdl/gmdr_pkg.sv -----
package gmdr_pkg;

  // Largest grid side and the widths that follow from it
  localparam int unsigned MaxSide = 256;
  localparam int unsigned PosW    = $clog2(MaxSide);
  localparam int unsigned SideW   = 9;

  // Datapath widths
  localparam int unsigned DataW = 32;
  localparam int unsigned DiffW = DataW + 2;
  localparam int unsigned FracW = 16;
  localparam int unsigned NumW  = DiffW + FracW;
  localparam int unsigned QuoW  = 32;
  localparam int unsigned CntW  = $clog2(QuoW);

  localparam logic [QuoW-1:0] QMax = {1'b0, {(QuoW-1){1'b1}}};
  localparam logic [QuoW-1:0] QMin = {1'b1, {(QuoW-1){1'b0}}};

  typedef struct packed {
    logic            start;
    logic [NumW-1:0]  num;
    logic [DiffW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [QuoW-1:0] quo;
  } div_res_t;

  function automatic logic [DiffW-1:0] sext(input logic [DataW-1:0] v);
    return {{(DiffW-DataW){v[DataW-1]}}, v};
  endfunction

endpackage

// ----- hdl/grid_mixed_difference_ratio_core.sv -----
// Mixed 2D difference ratio over a square grid. Cells of two cumulative grids A and B
// arrive in raster order, one beat per cell, cum_a in s_tdata_i[31:0] and cum_b in
// s_tdata_i[63:32]. For each cell the block forms dA and dB (cell - upper - left +
// upper-left, neighbours outside the grid taken as zero) and returns dB * 2^16 / dA
// as signed Q16.16, truncated toward zero. A zero dA gives ratio 0 with
// zero_divisor set; a quotient outside Q16.16 is clamped and flagged saturated.
// The final cell of the grid carries tlast. The previous row lives in one
// 256 x 64 RAM. Each item passes in turn through RAM read, difference,
// sign/magnitude setup, the radix-2 divider (skipped when dA is zero), which
// retires one quotient bit per cycle, and result hand-off; the next cell is
// accepted only after that. A finished result sits in the output register, so
// the next cell is taken while it waits. Writing grid_side (cfg_we_i) restarts
// at the first cell; values 0 and above 256 act as 1 and 256.
module grid_mixed_difference_ratio_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,   // grid_side
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,     // [31:0] cum_a, [63:32] cum_b
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,     // [31:0] ratio
  output logic [1:0]  m_tuser_o,     // [0] zero_divisor, [1] saturated
  output logic        m_tlast_o      // last_of_grid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;

  // position and side
  logic [gmdr_pkg::SideW-1:0] side_q;
  logic [gmdr_pkg::SideW-1:0] side_eff;
  logic [gmdr_pkg::SideW-1:0] side_m1;
  logic [gmdr_pkg::PosW-1:0]  col_q;
  logic [gmdr_pkg::PosW-1:0]  row_q;
  logic                       col_wrap;
  logic                       row_wrap;
  logic                       last_d;

  // per-item context
  logic                       s_acc;
  logic [gmdr_pkg::PosW-1:0]  slot_q;
  logic                       row_nz_q;
  logic                       col_nz_q;
  logic                       last_q;
  logic [gmdr_pkg::DataW-1:0] a_q;
  logic [gmdr_pkg::DataW-1:0] b_q;
  logic [gmdr_pkg::DataW-1:0] left_a_q;
  logic [gmdr_pkg::DataW-1:0] left_b_q;
  logic [gmdr_pkg::DataW-1:0] diag_a_q;
  logic [gmdr_pkg::DataW-1:0] diag_b_q;

  // row RAM: {b, a}
  logic                         ram_we;
  logic [2*gmdr_pkg::DataW-1:0] ram_rdata;

  // differences
  logic [gmdr_pkg::DataW-1:0]  up_a, up_b, lf_a, lf_b, dg_a, dg_b;
  logic [gmdr_pkg::DiffW-1:0]  da_d, db_d;
  logic [gmdr_pkg::DiffW-1:0]  da_q, db_q;
  logic [gmdr_pkg::DiffW-1:0]  mag_a, mag_b;
  logic                        da_zero;
  logic                        zero_q;
  logic                        neg_q;

  gmdr_pkg::div_req_t div_req;
  gmdr_pkg::div_res_t div_res;

  // result
  logic                        out_load;
  logic [gmdr_pkg::QuoW-1:0]   ratio_d;
  logic                        zero_d;
  logic                        sat_d;
  logic                        m_tvalid_q;
  logic [gmdr_pkg::QuoW-1:0]   m_tdata_q;
  logic [1:0]                  m_tuser_q;
  logic                        m_tlast_q;

  // ---------------------------------------------------------------------------
  // Side clamp and raster position
  // ---------------------------------------------------------------------------
  always_comb begin
    if (side_q == '0) begin
      side_eff = gmdr_pkg::SideW'(1);
    end else if (side_q > gmdr_pkg::SideW'(gmdr_pkg::MaxSide)) begin
      side_eff = gmdr_pkg::SideW'(gmdr_pkg::MaxSide);
    end else begin
      side_eff = side_q;
    end
  end

  assign side_m1  = side_eff - gmdr_pkg::SideW'(1);
  assign col_wrap = ({1'b0, col_q} + gmdr_pkg::SideW'(1)) >= side_eff;
  assign row_wrap = ({1'b0, row_q} + gmdr_pkg::SideW'(1)) >= side_eff;
  assign last_d   = (col_q == side_m1[gmdr_pkg::PosW-1:0]) &&
                    (row_q == side_m1[gmdr_pkg::PosW-1:0]);

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_acc      = s_tvalid_i & s_tready_o;

  // ---------------------------------------------------------------------------
  // Previous-row store: read at accept, written back once the old value is used
  // ---------------------------------------------------------------------------
  assign ram_we = (state_q == ST_DIFF);

  gmdr_ram #(
    .Width (2 * gmdr_pkg::DataW),
    .Depth (gmdr_pkg::MaxSide)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({b_q, a_q}),
    .re_i    (s_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Mixed difference; 34 bits hold the exact sum of four 32-bit terms
  // ---------------------------------------------------------------------------
  assign up_a = row_nz_q ? ram_rdata[gmdr_pkg::DataW-1:0] : '0;
  assign up_b = row_nz_q ? ram_rdata[2*gmdr_pkg::DataW-1:gmdr_pkg::DataW] : '0;
  assign lf_a = col_nz_q ? left_a_q : '0;
  assign lf_b = col_nz_q ? left_b_q : '0;
  assign dg_a = (row_nz_q && col_nz_q) ? diag_a_q : '0;
  assign dg_b = (row_nz_q && col_nz_q) ? diag_b_q : '0;

  assign da_d = gmdr_pkg::sext(a_q) - gmdr_pkg::sext(up_a)
              - gmdr_pkg::sext(lf_a) + gmdr_pkg::sext(dg_a);
  assign db_d = gmdr_pkg::sext(b_q) - gmdr_pkg::sext(up_b)
              - gmdr_pkg::sext(lf_b) + gmdr_pkg::sext(dg_b);

  // magnitudes for the unsigned divider; sign applied at the end
  assign mag_a   = da_q[gmdr_pkg::DiffW-1] ? (~da_q + gmdr_pkg::DiffW'(1)) : da_q;
  assign mag_b   = db_q[gmdr_pkg::DiffW-1] ? (~db_q + gmdr_pkg::DiffW'(1)) : db_q;
  assign da_zero = (da_q == '0);

  assign div_req.start = (state_q == ST_PREP) && !da_zero;
  assign div_req.num   = {mag_b, {gmdr_pkg::FracW{1'b0}}};
  assign div_req.den   = mag_a;

  gmdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // ---------------------------------------------------------------------------
  // Sign, clamp and flags
  // ---------------------------------------------------------------------------
  always_comb begin
    ratio_d = div_res.quo;
    zero_d  = 1'b0;
    sat_d   = 1'b0;
    if (zero_q) begin
      ratio_d = '0;
      zero_d  = 1'b1;
    end else if (div_res.ovf) begin
      ratio_d = neg_q ? gmdr_pkg::QMin : gmdr_pkg::QMax;
      sat_d   = 1'b1;
    end else if (neg_q) begin
      if (div_res.quo > gmdr_pkg::QMin) begin
        ratio_d = gmdr_pkg::QMin;
        sat_d   = 1'b1;
      end else begin
        ratio_d = ~div_res.quo + gmdr_pkg::QuoW'(1);
      end
    end else if (div_res.quo[gmdr_pkg::QuoW-1]) begin
      ratio_d = gmdr_pkg::QMax;
      sat_d   = 1'b1;
    end
  end

  assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready_i);

  // ---------------------------------------------------------------------------
  // Sequencer, position and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      side_q     <= gmdr_pkg::SideW'(gmdr_pkg::MaxSide);
      col_q      <= '0;
      row_q      <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= '0;
      m_tlast_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
        col_q  <= '0;
        row_q  <= '0;
      end else if (s_acc) begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_q + gmdr_pkg::PosW'(1);
        end else begin
          col_q <= col_q + gmdr_pkg::PosW'(1);
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          state_q <= da_zero ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          if (div_res.done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_tdata_q  <= ratio_d;
        m_tuser_q  <= {sat_d, zero_d};
        m_tlast_q  <= last_q;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_q      <= s_tdata_i[gmdr_pkg::DataW-1:0];
      b_q      <= s_tdata_i[2*gmdr_pkg::DataW-1:gmdr_pkg::DataW];
      slot_q   <= col_q;
      row_nz_q <= (row_q != '0);
      col_nz_q <= (col_q != '0);
      last_q   <= last_d;
    end
    if (state_q == ST_DIFF) begin
      da_q     <= da_d;
      db_q     <= db_d;
      // old upper value is the diagonal of the next column
      diag_a_q <= ram_rdata[gmdr_pkg::DataW-1:0];
      diag_b_q <= ram_rdata[2*gmdr_pkg::DataW-1:gmdr_pkg::DataW];
      left_a_q <= a_q;
      left_b_q <= b_q;
    end
    if (state_q == ST_PREP) begin
      zero_q <= da_zero;
      neg_q  <= da_q[gmdr_pkg::DiffW-1] ^ db_q[gmdr_pkg::DiffW-1];
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;
  assign m_tlast_o  = m_tlast_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_zero_div_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[0]) |-> (m_tdata_o == '0 && !m_tuser_o[1]))
    else $error("zero divisor result not clean");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");

  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < side_eff) && ({1'b0, row_q} < side_eff))
    else $error("raster position outside grid");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0 && row_q == '0))
    else $error("side write did not restart the grid");

endmodule

// ----- hdl/gmdr_ram.sv -----
module gmdr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/gmdr_div.sv -----
module gmdr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gmdr_pkg::div_req_t  req_i,
  output gmdr_pkg::div_res_t  res_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [gmdr_pkg::CntW-1:0]     cnt_q;
  logic [gmdr_pkg::DiffW-1:0]    rem_q;
  logic [gmdr_pkg::DiffW-1:0]    den_q;
  logic [gmdr_pkg::QuoW-1:0]     sh_q;
  logic                          ovf_q;
  logic [gmdr_pkg::DiffW:0]      trial;
  logic                          fits;
  logic [gmdr_pkg::DiffW-1:0]    rem_d;

  // one quotient bit per step: shift in next dividend bit, trial subtract
  assign trial = {rem_q, sh_q[gmdr_pkg::QuoW-1]} - {1'b0, den_q};
  assign fits  = ~trial[gmdr_pkg::DiffW];
  assign rem_d = fits ? trial[gmdr_pkg::DiffW-1:0]
                      : {rem_q[gmdr_pkg::DiffW-2:0], sh_q[gmdr_pkg::QuoW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + gmdr_pkg::CntW'(1);
        if (cnt_q == {gmdr_pkg::CntW{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // high dividend bits form the starting remainder; if they already reach
  // the divisor the quotient cannot fit in 32 bits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= gmdr_pkg::DiffW'(req_i.num[gmdr_pkg::NumW-1:gmdr_pkg::QuoW]);
      sh_q  <= req_i.num[gmdr_pkg::QuoW-1:0];
      den_q <= req_i.den;
      ovf_q <= gmdr_pkg::DiffW'(req_i.num[gmdr_pkg::NumW-1:gmdr_pkg::QuoW]) >= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[gmdr_pkg::QuoW-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = sh_q;

endmodule

// ----- sim/tb.sv -----
module tb;

  // Run shape
  localparam int unsigned CellTarget = 2000;    // random cells before stopping
  localparam int unsigned CalmAfter  = 1700;    // no idling from here on
  localparam int unsigned Settle     = 60;      // longer than one item's pass through the core
  localparam int unsigned CycleLimit = 800000;

  // One result beat, split into its fields
  typedef struct packed {
    logic [gmdr_pkg::QuoW-1:0] ratio;
    logic                      zero_div;
    logic                      sat;
    logic                      last;
  } grid_ratio_t;

  // Directed table: either a side write or one cell
  typedef enum logic {STEP_CELL, STEP_SIDE} step_kind_e;

  typedef struct packed {
    step_kind_e                 kind;
    logic [gmdr_pkg::SideW-1:0] side;
    logic [gmdr_pkg::DataW-1:0] cum_a;
    logic [gmdr_pkg::DataW-1:0] cum_b;
    logic                       typed;   // 1: want holds the expected beat
    grid_ratio_t                want;
  } step_row_t;

  localparam int DirN = 22;
  localparam step_row_t Directed [DirN] = '{
    // 2x2 grid, small values: plain ratio, zero divisor, negative, saturation + last
    '{STEP_SIDE, 9'd2, 32'h0, 32'h0, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0001_0000, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0001, 32'h0000_0005, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0002, 32'hFFFF_FFFF, 1'b1, '{32'hFFFE_0000, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0003, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1}},
    // second grid on the same side: input extremes, 34-bit differences
    '{STEP_CELL, 9'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'hFFFF_0001, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'hFFFF_0000, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}},
    // side 1: every cell is its own grid, no neighbours
    '{STEP_SIDE, 9'd1, 32'h0, 32'h0, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1}},
    '{STEP_CELL, 9'd0, 32'h0000_0001, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b1, 1'b1}},
    '{STEP_CELL, 9'd0, 32'h0000_0000, 32'h0000_007B, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 1'b1}},
    '{STEP_CELL, 9'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0001_0000, 1'b0, 1'b0, 1'b1}},
    '{STEP_CELL, 9'd0, 32'h0000_0003, 32'h0000_0001, 1'b1, '{32'h0000_5555, 1'b0, 1'b0, 1'b1}},
    '{STEP_CELL, 9'd0, 32'hFFFF_FFFD, 32'h0000_0001, 1'b1, '{32'hFFFF_AAAB, 1'b0, 1'b0, 1'b1}},
    // side 0 behaves as side 1
    '{STEP_SIDE, 9'd0, 32'h0, 32'h0, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0007, 32'hFFFF_FFF9, 1'b1, '{32'hFFFF_0000, 1'b0, 1'b0, 1'b1}},
    // side 3, first row only; predictor decides
    '{STEP_SIDE, 9'd3, 32'h0, 32'h0, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0005, 32'h0000_000A, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0005, 32'h0000_000A, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{STEP_CELL, 9'd0, 32'h0000_0009, 32'h7FFF_FFFF, 1'b0, '{32'h0, 1'b0, 1'b0, 1'b0}}
  };

  // DUT ports; every input starts at a known value
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [63:0] s_tdata_i   = '0;
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [31:0] m_tdata_o;
  logic [1:0]  m_tuser_o;
  logic        m_tlast_o;

  grid_mixed_difference_ratio_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor: its own copy of the side register, row buffer and position
  // ---------------------------------------------------------------------------
  logic [gmdr_pkg::SideW-1:0] side_reg;
  bit   [gmdr_pkg::DataW-1:0] upper_a [gmdr_pkg::MaxSide];
  bit   [gmdr_pkg::DataW-1:0] upper_b [gmdr_pkg::MaxSide];
  bit   [gmdr_pkg::DataW-1:0] left_a, left_b, diag_a, diag_b;
  int unsigned                row_pos, col_pos;

  grid_ratio_t expected_ratios [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned cells_sent     = 0;
  bit          calm           = 1'b0;   // set: neither side idles any more

  function automatic longint widen(input logic [gmdr_pkg::DataW-1:0] v);
    return {{(64-gmdr_pkg::DataW){v[gmdr_pkg::DataW-1]}}, v};
  endfunction

  // 0 acts as 1, anything above the largest side acts as the largest side
  function automatic int unsigned side_in_use();
    if (side_reg == 0) return 1;
    if (side_reg > gmdr_pkg::MaxSide) return gmdr_pkg::MaxSide;
    return 32'(side_reg);
  endfunction

  // A side write also restarts the grid at its first cell
  function automatic void load_side(input logic [gmdr_pkg::SideW-1:0] v);
    side_reg = v;
    row_pos  = 0;
    col_pos  = 0;
    left_a   = '0;
    left_b   = '0;
    diag_a   = '0;
    diag_b   = '0;
  endfunction

  // Neighbour part of the mixed difference: upper + left - upper-left
  function automatic longint neighbours(input bit use_b);
    longint sum;
    sum = 0;
    if (row_pos != 0) sum += widen(use_b ? upper_b[8'(col_pos)] : upper_a[8'(col_pos)]);
    if (col_pos != 0) begin
      sum += widen(use_b ? left_b : left_a);
      if (row_pos != 0) sum -= widen(use_b ? diag_b : diag_a);
    end
    return sum;
  endfunction

  // Ratio of the cell's B difference over its A difference, then advance
  function automatic grid_ratio_t predict_ratio(input logic [gmdr_pkg::DataW-1:0] a,
                                                input logic [gmdr_pkg::DataW-1:0] b);
    int unsigned side_n;
    logic [7:0]  slot;
    longint      da, db, q;
    grid_ratio_t res;
    side_n = side_in_use();
    slot   = 8'(col_pos);
    da     = widen(a) - neighbours(1'b0);
    db     = widen(b) - neighbours(1'b1);
    res    = '0;
    if (da == 0) begin
      res.zero_div = 1'b1;
    end else begin
      q = (db * 64'sd65536) / da;   // truncates toward zero
      if (q > widen(gmdr_pkg::QMax)) begin
        res.ratio = gmdr_pkg::QMax;
        res.sat   = 1'b1;
      end else if (q < widen(gmdr_pkg::QMin)) begin
        res.ratio = gmdr_pkg::QMin;
        res.sat   = 1'b1;
      end else begin
        res.ratio = q[31:0];
      end
    end
    res.last = (row_pos == side_n - 1) && (col_pos == side_n - 1);
    // old upper value is the diagonal of the next column
    diag_a        = upper_a[slot];
    diag_b        = upper_b[slot];
    upper_a[slot] = a;
    upper_b[slot] = b;
    left_a        = a;
    left_b        = b;
    if (col_pos + 1 >= side_n) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= side_n) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [gmdr_pkg::DataW-1:0] any_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Wanted difference: zero, unit, small, power of two, full range, full range shifted down, up to 16 bits; either sign
  function automatic longint pick_diff();
    longint d;
    case ($urandom_range(0, 7))
      0:       d = 0;
      1:       d = 1;
      2:       d = longint'($urandom_range(0, 2000)) - 1000;
      3:       d = longint'(1) << $urandom_range(0, 31);
      4:       d = widen($urandom);
      5:       d = widen($urandom) >>> 12;
      6:       d = widen($urandom) >>> 24;
      default: d = longint'($urandom_range(1, 65535));
    endcase
    if ($urandom_range(0, 1) == 1) d = -d;
    return d;
  endfunction

  // Mostly cells built so the differences land where we want them (exact
  // cumulative grids); the rest are raw words for noise and wrap-around.
  task automatic make_cell(output logic [gmdr_pkg::DataW-1:0] a,
                           output logic [gmdr_pkg::DataW-1:0] b);
    if ($urandom_range(0, 9) < 3) begin
      a = any_word();
      b = any_word();
    end else begin
      a = 32'(neighbours(1'b0) + pick_diff());
      b = 32'(neighbours(1'b1) + pick_diff());
    end
  endtask

  // One input beat; the expectation is queued at the accepting edge.
  // tvalid stays high between back-to-back cells and drops only for a gap.
  task automatic send_cell(input logic [gmdr_pkg::DataW-1:0] a,
                           input logic [gmdr_pkg::DataW-1:0] b,
                           input logic typed, input grid_ratio_t want);
    grid_ratio_t pred;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {b, a};
    do @(posedge clk_i); while (!s_tready_o);
    pred = predict_ratio(a, b);
    if (typed) pred = want;
    expected_ratios = {expected_ratios, pred};
  endtask

  // Side writes only with nothing in flight
  task automatic write_side(input logic [gmdr_pkg::SideW-1:0] v);
    s_tvalid_i <= 1'b0;
    while (expected_ratios.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    load_side(v);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random grids, drain
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [gmdr_pkg::DataW-1:0] a, b;
    logic [gmdr_pkg::SideW-1:0] side_val;
    int unsigned                eff, n, big_runs;
    big_runs = 0;
    load_side(9'd256);   // reset value of the side register
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirN; i++) begin
      if (Directed[i].kind == STEP_SIDE) begin
        write_side(Directed[i].side);
      end else begin
        send_cell(Directed[i].cum_a, Directed[i].cum_b, Directed[i].typed, Directed[i].want);
      end
    end

    // Random grids: mostly small sides, whole grids with an occasional
    // partial one cut short by the next side write. Up to two runs at the
    // largest side (one written as 511) reach into the second row.
    while (cells_sent < CellTarget) begin
      case ($urandom_range(0, 9))
        0: side_val = 9'($urandom_range(0, 1));
        1: begin
          if (big_runs < 2) begin
            side_val = (big_runs == 0) ? 9'd511 : 9'd256;
            big_runs++;
          end else begin
            side_val = 9'($urandom_range(2, 12));
          end
        end
        default: side_val = 9'($urandom_range(2, 12));
      endcase
      write_side(side_val);
      eff = side_in_use();
      if (eff == gmdr_pkg::MaxSide) begin
        n = 300;
      end else begin
        n = eff * eff * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(0, eff * eff - 1);
      end
      for (int unsigned k = 0; k < n && cells_sent < CellTarget; k++) begin
        make_cell(a, b);
        send_cell(a, b, 1'b0, '0);
        cells_sent++;
        if (cells_sent >= CalmAfter) calm = 1'b1;
      end
    end

    calm = 1'b1;
    s_tvalid_i <= 1'b0;
    while (expected_ratios.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result-side backpressure: random stall bursts until the calm part
  initial begin : sink_pacing
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s expected %h, got %h", $time, what, want, got);
  endtask

  grid_ratio_t head;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_ratios.size() == 0) begin
        note_mismatch("unexpected beat, ratio", 32'h0, m_tdata_o);
      end else begin
        head = expected_ratios.pop_front();
        if (m_tdata_o !== head.ratio) note_mismatch("ratio", head.ratio, m_tdata_o);
        if (m_tuser_o[0] !== head.zero_div)
          note_mismatch("zero_divisor", 32'(head.zero_div), 32'(m_tuser_o[0]));
        if (m_tuser_o[1] !== head.sat)
          note_mismatch("saturated", 32'(head.sat), 32'(m_tuser_o[1]));
        if (m_tlast_o !== head.last)
          note_mismatch("last_of_grid", 32'(head.last), 32'(m_tlast_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ----- grid_mixed_difference_ratio_core.f -----
hdl/gmdr_pkg.sv
hdl/gmdr_ram.sv
hdl/gmdr_div.sv
hdl/grid_mixed_difference_ratio_core.sv
sim/tb.sv
